/* design/trs_pkg.sv */
`default_nettype none
package trs_pkg;

	// Shared widths and pipeline depths
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W = 5;
	localparam int XW = 32;
	localparam int ZW = 33;
	localparam int RW = 33;
	localparam int PREP_LAT = 4;
	localparam int LAT_TRIG = PREP_LAT + CORDIC_STEPS + 1;
	localparam int MAT_LAT = 5;
	localparam int TOTAL_LAT = LAT_TRIG + MAT_LAT;
	localparam logic signed [XW-1:0] CORDIC_GAIN = 32'sd652032874;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic neg;
	} cordic_t;

	typedef struct packed {
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic signed [31:0] size_z;
	} side_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [31:0] m03;
		logic signed [31:0] m13;
		logic signed [31:0] m23;
	} mat_t;

	// Arctangent per step in binary angle units
	function automatic logic [31:0] atan_tab(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// Q2.30 product with round half up
	function automatic logic signed [XW-1:0] mul30(input logic signed [XW-1:0] a,
			input logic signed [XW-1:0] b);
		logic signed [63:0] ae;
		logic signed [63:0] be;
		logic signed [63:0] p;
		ae = a;
		be = b;
		p = ae * be + 64'sd536870912;
		return p[61:30];
	endfunction

endpackage
`default_nettype wire

/* design/trs_angle_prep.sv */
`default_nettype none
module trs_angle_prep
	import trs_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic signed [31:0] angle,
	output cordic_t start
);

	logic [17:0] u18;
	logic [33:0] pq;
	logic [16:0] u_s1;
	logic [15:0] low_s1;
	logic [7:0] qm_s1;
	logic [16:0] rm_full;
	logic [8:0] rm;
	logic [29:0] w8;
	logic [8:0] rm_s2;
	logic [29:0] w8_s2;
	logic [60:0] pd;
	logic [32:0] pk;
	logic [24:0] qd_s3;
	logic [31:0] rmk_s3;
	logic [31:0] t;
	logic [31:0] t_fold;
	logic fold;
	cordic_t start_s4;

	// Whole degrees offset to a positive value, quotient by 360 via reciprocal
	assign u18 = {{2{angle[31]}}, angle[31:16]} + 18'd33120;
	assign pq = {17'b0, u18[16:0]} * 34'd93207;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u18[16:0];
			low_s1 <= angle[15:0];
			qm_s1 <= pq[32:25];
		end
	end

	// Remainder in degrees, then the scaled fraction divided by 8
	assign rm_full = u_s1 - 17'({9'b0, qm_s1} * 17'd360);
	assign rm = rm_full[8:0];
	assign w8 = {1'b0, low_s1, 13'b0} + {16'b0, rm, 5'b0} + 30'd22;

	always_ff @(posedge clk) begin
		if (en) begin
			rm_s2 <= rm;
			w8_s2 <= w8;
		end
	end

	// Divide by 45 and weight whole degrees by one turn over 360
	assign pd = {31'b0, w8_s2} * 61'd1527099484;
	assign pk = {24'b0, rm_s2} * 33'd11930464;

	always_ff @(posedge clk) begin
		if (en) begin
			qd_s3 <= pd[60:36];
			rmk_s3 <= pk[31:0];
		end
	end

	// Binary angle and fold into the right half plane
	assign t = rmk_s3 + {7'b0, qd_s3};
	assign fold = t[31] ^ t[30];
	assign t_fold = fold ? {~t[31], t[30:0]} : t;

	always_ff @(posedge clk) begin
		if (en) begin
			start_s4.x <= CORDIC_GAIN;
			start_s4.y <= '0;
			start_s4.z <= {t_fold[31], t_fold};
			start_s4.neg <= fold;
		end
	end

	assign start = start_s4;

endmodule
`default_nettype wire

/* design/trs_cordic_cell.sv */
`default_nettype none
module trs_cordic_cell
	import trs_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic [STEP_W-1:0] step,
	input cordic_t d,
	output cordic_t q
);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] a_ext;
	cordic_t nxt;
	cordic_t q_q;

	assign xs = d.x >>> step;
	assign ys = d.y >>> step;
	assign a_ext = {1'b0, atan_tab(step)};

	// Rotate toward zero residual angle
	always_comb begin
		nxt.neg = d.neg;
		if (!d.z[ZW-1]) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - a_ext;
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + a_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= nxt;
		end
	end

	assign q = q_q;

endmodule
`default_nettype wire

/* design/trs_sincos.sv */
`default_nettype none
module trs_sincos
	import trs_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic signed [31:0] angle,
	output logic signed [XW-1:0] cos_v,
	output logic signed [XW-1:0] sin_v
);

	cordic_t chain [CORDIC_STEPS+1];
	logic signed [XW-1:0] cos_q;
	logic signed [XW-1:0] sin_q;

	trs_angle_prep u_prep (
		.clk(clk),
		.en(en),
		.angle(angle),
		.start(chain[0])
	);

	// Row of rotation cells, one step each
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		trs_cordic_cell u_cell (
			.clk(clk),
			.en(en),
			.step(STEP_W'(i)),
			.d(chain[i]),
			.q(chain[i+1])
		);
	end

	// Undo the half-turn fold
	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= chain[CORDIC_STEPS].neg ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
			sin_q <= chain[CORDIC_STEPS].neg ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
		end
	end

	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule
`default_nettype wire

/* design/trs_matrix.sv */
`default_nettype none
module trs_matrix
	import trs_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic signed [XW-1:0] cx,
	input wire logic signed [XW-1:0] sx,
	input wire logic signed [XW-1:0] cy,
	input wire logic signed [XW-1:0] sy,
	input wire logic signed [XW-1:0] cz,
	input wire logic signed [XW-1:0] sz,
	input side_t side,
	output mat_t mat
);

	logic signed [XW-1:0] ysx_s1, ycx_s1, cycz_s1, cysz_s1, sycx_s1, cxsz_s1;
	logic signed [XW-1:0] cxcz_s1, sycz_s1, sysz_s1, cycx_s1, sz_s1, cz_s1, sx_s1;
	logic signed [XW-1:0] t1_s2, t2_s2, t3_s2, t4_s2;
	logic signed [XW-1:0] cycz_s2, cysz_s2, sycx_s2, cxsz_s2, cxcz_s2, sycz_s2;
	logic signed [XW-1:0] sysz_s2, cycx_s2, sx_s2;
	logic signed [RW-1:0] r_s3 [9];
	logic signed [35:0] v_s4 [9];
	side_t side_s1, side_s2, side_s3, side_s4;
	logic signed [31:0] size_k [9];
	logic signed [31:0] sat_k [9];
	mat_t mat_q;

	// First products of sines and cosines
	always_ff @(posedge clk) begin
		if (en) begin
			ysx_s1 <= mul30(sy, sx);
			ycx_s1 <= mul30(cy, sx);
			cycz_s1 <= mul30(cy, cz);
			cysz_s1 <= mul30(cy, sz);
			sycx_s1 <= mul30(sy, cx);
			cxsz_s1 <= mul30(cx, sz);
			cxcz_s1 <= mul30(cx, cz);
			sycz_s1 <= mul30(sy, cz);
			sysz_s1 <= mul30(sy, sz);
			cycx_s1 <= mul30(cy, cx);
			sz_s1 <= sz;
			cz_s1 <= cz;
			sx_s1 <= sx;
			side_s1 <= side;
		end
	end

	// Third factor of the mixed terms
	always_ff @(posedge clk) begin
		if (en) begin
			t1_s2 <= mul30(ysx_s1, sz_s1);
			t2_s2 <= mul30(ysx_s1, cz_s1);
			t3_s2 <= mul30(ycx_s1, sz_s1);
			t4_s2 <= mul30(ycx_s1, cz_s1);
			cycz_s2 <= cycz_s1;
			cysz_s2 <= cysz_s1;
			sycx_s2 <= sycx_s1;
			cxsz_s2 <= cxsz_s1;
			cxcz_s2 <= cxcz_s1;
			sycz_s2 <= sycz_s1;
			sysz_s2 <= sysz_s1;
			cycx_s2 <= cycx_s1;
			sx_s2 <= sx_s1;
			side_s2 <= side_s1;
		end
	end

	// Rotation entries
	always_ff @(posedge clk) begin
		if (en) begin
			r_s3[0] <= RW'(cycz_s2) + RW'(t1_s2);
			r_s3[1] <= RW'(t2_s2) - RW'(cysz_s2);
			r_s3[2] <= RW'(sycx_s2);
			r_s3[3] <= RW'(cxsz_s2);
			r_s3[4] <= RW'(cxcz_s2);
			r_s3[5] <= -RW'(sx_s2);
			r_s3[6] <= RW'(t3_s2) - RW'(sycz_s2);
			r_s3[7] <= RW'(sysz_s2) + RW'(t4_s2);
			r_s3[8] <= RW'(cycx_s2);
			side_s3 <= side_s2;
		end
	end

	assign size_k[0] = side_s3.size_x;
	assign size_k[1] = side_s3.size_y;
	assign size_k[2] = side_s3.size_z;
	assign size_k[3] = side_s3.size_x;
	assign size_k[4] = side_s3.size_y;
	assign size_k[5] = side_s3.size_z;
	assign size_k[6] = side_s3.size_x;
	assign size_k[7] = side_s3.size_y;
	assign size_k[8] = side_s3.size_z;

	// Scale each column
	for (genvar k = 0; k < 9; k++) begin : g_scale
		logic signed [65:0] re;
		logic signed [65:0] se;
		logic signed [65:0] p;
		assign re = r_s3[k];
		assign se = size_k[k];
		assign p = re * se + 66'sd536870912;

		always_ff @(posedge clk) begin
			if (en) begin
				v_s4[k] <= p[65:30];
			end
		end

		// Clamp to the signed 32-bit range
		always_comb begin
			if (v_s4[k] > 36'sd2147483647) begin
				sat_k[k] = 32'sh7FFFFFFF;
			end else if (v_s4[k] < -36'sd2147483648) begin
				sat_k[k] = 32'sh80000000;
			end else begin
				sat_k[k] = v_s4[k][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_q.m00 <= sat_k[0];
			mat_q.m01 <= sat_k[1];
			mat_q.m02 <= sat_k[2];
			mat_q.m10 <= sat_k[3];
			mat_q.m11 <= sat_k[4];
			mat_q.m12 <= sat_k[5];
			mat_q.m20 <= sat_k[6];
			mat_q.m21 <= sat_k[7];
			mat_q.m22 <= sat_k[8];
			mat_q.m03 <= side_s4.move_x;
			mat_q.m13 <= side_s4.move_y;
			mat_q.m23 <= side_s4.move_z;
		end
	end

	assign mat = mat_q;

endmodule
`default_nettype wire

/* design/trs_model_matrix_compose.sv */
// Request to result passes 4 angle reduction stages, CORDIC_STEPS rotation
// cells, 1 sign fix, 5 matrix stages and 1 output register.
// Throughput: one request per cycle; all stages advance together while the skid
// register is empty, so a stalled output holds one result and one more in the skid.
// Reset: arst_n clears the valid chain, output and skid flags; data is not reset.
`default_nettype none
module trs_model_matrix_compose
	import trs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] move_x,
	input wire logic signed [31:0] move_y,
	input wire logic signed [31:0] move_z,
	input wire logic signed [31:0] angle_x,
	input wire logic signed [31:0] angle_y,
	input wire logic signed [31:0] angle_z,
	input wire logic signed [31:0] size_x,
	input wire logic signed [31:0] size_y,
	input wire logic signed [31:0] size_z,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m20,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22,
	output logic signed [31:0] m03,
	output logic signed [31:0] m13,
	output logic signed [31:0] m23
);

	logic en;
	logic signed [XW-1:0] cx, sx, cy, sy, cz, sz;
	side_t side_in;
	side_t side_q [LAT_TRIG];
	logic vld_q [TOTAL_LAT];
	mat_t pipe_mat;
	mat_t out_q;
	mat_t skid_q;
	logic out_valid_q;
	logic skid_full_q;

	assign en = !skid_full_q;
	assign in_stall = skid_full_q;

	assign side_in.move_x = move_x;
	assign side_in.move_y = move_y;
	assign side_in.move_z = move_z;
	assign side_in.size_x = size_x;
	assign side_in.size_y = size_y;
	assign side_in.size_z = size_z;

	trs_sincos u_trig_x (.clk(clk), .en(en), .angle(angle_x), .cos_v(cx), .sin_v(sx));
	trs_sincos u_trig_y (.clk(clk), .en(en), .angle(angle_y), .cos_v(cy), .sin_v(sy));
	trs_sincos u_trig_z (.clk(clk), .en(en), .angle(angle_z), .cos_v(cz), .sin_v(sz));

	// Hold translation and scale alongside the angle pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int i = 1; i < LAT_TRIG; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	trs_matrix u_mat (
		.clk(clk),
		.en(en),
		.cx(cx),
		.sx(sx),
		.cy(cy),
		.sy(sy),
		.cz(cz),
		.sz(sz),
		.side(side_q[LAT_TRIG-1]),
		.mat(pipe_mat)
	);

	// Advance request valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < TOTAL_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Output register with skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= skid_full_q || vld_q[TOTAL_LAT-1];
			skid_full_q <= 1'b0;
		end else if (!skid_full_q && vld_q[TOTAL_LAT-1]) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_full_q ? skid_q : pipe_mat;
		end else if (!skid_full_q) begin
			skid_q <= pipe_mat;
		end
	end

	assign out_valid = out_valid_q;
	assign m00 = out_q.m00;
	assign m01 = out_q.m01;
	assign m02 = out_q.m02;
	assign m10 = out_q.m10;
	assign m11 = out_q.m11;
	assign m12 = out_q.m12;
	assign m20 = out_q.m20;
	assign m21 = out_q.m21;
	assign m22 = out_q.m22;
	assign m03 = out_q.m03;
	assign m13 = out_q.m13;
	assign m23 = out_q.m23;

endmodule
`default_nettype wire

/* sim/trs_compose_checker.sv */
`timescale 1ns / 1ps
module trs_compose_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic signed [31:0] move_x,
	input wire logic signed [31:0] move_y,
	input wire logic signed [31:0] move_z,
	input wire logic signed [31:0] angle_x,
	input wire logic signed [31:0] angle_y,
	input wire logic signed [31:0] angle_z,
	input wire logic signed [31:0] size_x,
	input wire logic signed [31:0] size_y,
	input wire logic signed [31:0] size_z,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [31:0] m00,
	input wire logic signed [31:0] m01,
	input wire logic signed [31:0] m02,
	input wire logic signed [31:0] m10,
	input wire logic signed [31:0] m11,
	input wire logic signed [31:0] m12,
	input wire logic signed [31:0] m20,
	input wire logic signed [31:0] m21,
	input wire logic signed [31:0] m22,
	input wire logic signed [31:0] m03,
	input wire logic signed [31:0] m13,
	input wire logic signed [31:0] m23,
	output int fail_count,
	output int pending
);
	import trs_pkg::*;

	localparam int FRAC = 16;
	localparam logic signed [63:0] HALF30 = 64'sd536870912;

	logic [31:0] rot_turn [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

	mat_t matrix_queue[$];

	// Q2.30 product, round half up
	function automatic logic signed [63:0] q30_product(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return (a * b + HALF30) >>> 30;
	endfunction

	// Degrees to sine and cosine in Q2.30
	task automatic angle_trig(input logic signed [31:0] deg, output logic signed [63:0] c,
			output logic signed [63:0] s);
		logic signed [63:0] modulus;
		logic signed [63:0] r;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
		logic [63:0] t;
		logic flip;
		modulus = 64'sd360 <<< FRAC;
		r = 64'(deg) % modulus;
		if (r < 0) r += modulus;
		t = ((64'(r) << (32 - FRAC)) + 64'd180) / 64'd360;
		t &= 64'hFFFF_FFFF;
		flip = 1'b0;
		if (t >= 64'h4000_0000 && t < 64'hC000_0000) begin
			t = (t + 64'h8000_0000) & 64'hFFFF_FFFF;
			flip = 1'b1;
		end
		z = 64'(signed'(t[31:0]));
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			logic signed [63:0] xs;
			logic signed [63:0] ys;
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= 64'(rot_turn[i]);
			end else begin
				x += ys;
				y -= xs;
				z += 64'(rot_turn[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic logic signed [31:0] scale_entry(input logic signed [63:0] rot,
			input logic signed [31:0] size);
		logic signed [63:0] v;
		v = (rot * 64'(size) + HALF30) >>> 30;
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Compose expected matrix for one request
	task automatic compose_matrix(output mat_t m);
		logic signed [63:0] cx, sx, cy, sy, cz, sz, ysx, ycx;
		logic signed [63:0] r [9];
		angle_trig(angle_x, cx, sx);
		angle_trig(angle_y, cy, sy);
		angle_trig(angle_z, cz, sz);
		ysx = q30_product(sy, sx);
		ycx = q30_product(cy, sx);
		r[0] = q30_product(cy, cz) + q30_product(ysx, sz);
		r[1] = q30_product(ysx, cz) - q30_product(cy, sz);
		r[2] = q30_product(sy, cx);
		r[3] = q30_product(cx, sz);
		r[4] = q30_product(cx, cz);
		r[5] = -sx;
		r[6] = q30_product(ycx, sz) - q30_product(sy, cz);
		r[7] = q30_product(sy, sz) + q30_product(ycx, cz);
		r[8] = q30_product(cy, cx);
		m.m00 = scale_entry(r[0], size_x);
		m.m01 = scale_entry(r[1], size_y);
		m.m02 = scale_entry(r[2], size_z);
		m.m10 = scale_entry(r[3], size_x);
		m.m11 = scale_entry(r[4], size_y);
		m.m12 = scale_entry(r[5], size_z);
		m.m20 = scale_entry(r[6], size_x);
		m.m21 = scale_entry(r[7], size_y);
		m.m22 = scale_entry(r[8], size_z);
		m.m03 = move_x;
		m.m13 = move_y;
		m.m23 = move_z;
	endtask

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Predict on accepted requests, compare on accepted results
	always @(posedge clk) begin
		mat_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				compose_matrix(want);
				matrix_queue.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (matrix_queue.size() == 0) begin
					$display("result with no request waiting at %0t", $realtime);
					fail_count++;
				end else begin
					want = matrix_queue.pop_front();
					if (m00 !== want.m00) report_mismatch("m00", m00, want.m00);
					if (m01 !== want.m01) report_mismatch("m01", m01, want.m01);
					if (m02 !== want.m02) report_mismatch("m02", m02, want.m02);
					if (m10 !== want.m10) report_mismatch("m10", m10, want.m10);
					if (m11 !== want.m11) report_mismatch("m11", m11, want.m11);
					if (m12 !== want.m12) report_mismatch("m12", m12, want.m12);
					if (m20 !== want.m20) report_mismatch("m20", m20, want.m20);
					if (m21 !== want.m21) report_mismatch("m21", m21, want.m21);
					if (m22 !== want.m22) report_mismatch("m22", m22, want.m22);
					if (m03 !== want.m03) report_mismatch("m03", m03, want.m03);
					if (m13 !== want.m13) report_mismatch("m13", m13, want.m13);
					if (m23 !== want.m23) report_mismatch("m23", m23, want.m23);
				end
			end
			pending = matrix_queue.size();
		end
	end
endmodule

/* sim/tb_trs_model_matrix_compose.sv */
`timescale 1ns / 1ps
module tb_trs_model_matrix_compose;
	import trs_pkg::*;

	localparam int RANDOM_REQUESTS = 830;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] move_x, move_y, move_z;
	logic signed [31:0] angle_x, angle_y, angle_z;
	logic signed [31:0] size_x, size_y, size_z;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, m03, m13, m23;
	int fail_count;
	int pending;
	int cycle_count;
	logic hold_off;
	logic stimulus_done;

	trs_model_matrix_compose i_dut (.*);

	trs_compose_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Random 32-bit word biased toward edge values
	function automatic logic signed [31:0] edgy_word();
		case ($urandom_range(0, 7))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			2: return 32'sd0;
			3: return 32'sh00010000 * $signed($urandom_range(0, 720)) - 32'sh01680000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] random_angle();
		case ($urandom_range(0, 5))
			0: return edgy_word();
			1: return 32'sh005A0000 * $signed($urandom_range(0, 8)) - 32'sh01680000;
			default: return $signed($urandom_range(0, 32'h02D00000)) - 32'sh01680000;
		endcase
	endfunction

	function automatic logic signed [31:0] random_size();
		case ($urandom_range(0, 5))
			0: return edgy_word();
			default: return $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
		endcase
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(input logic signed [31:0] tx, ty, tz, ax, ay, az,
			sx, sy, sz);
		move_x <= tx; move_y <= ty; move_z <= tz;
		angle_x <= ax; angle_y <= ay; angle_z <= az;
		size_x <= sx; size_y <= sy; size_z <= sz;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random();
		send_request(edgy_word(), edgy_word(), edgy_word(), random_angle(),
			random_angle(), random_angle(), random_size(), random_size(), random_size());
	endtask

	// Receiver: random stall pattern, with one long hold-off window
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) out_stall <= 1'b1;
			else if (stimulus_done) out_stall <= ($urandom_range(0, 3) == 0);
			else case (cycle_count / 200 % 3)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (cycle_count == 400);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (150) @(negedge clk);
		hold_off = 1'b0;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic signed [31:0] one;
		logic signed [31:0] corner_angle [10];
		one = 32'sh00010000;
		corner_angle = '{32'sd0, 32'sh005A0000, 32'sh00B40000, 32'sh010E0000,
			32'sh01680000, -32'sh005A0000, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh002D0000, 32'sh00000001};
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{move_x, move_y, move_z, angle_x, angle_y, angle_z} = '0;
		{size_x, size_y, size_z} = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: quadrant edges, wrap extremes, saturating scales
		send_request(0, 0, 0, 0, 0, 0, one, one, one);
		for (int i = 0; i < 10; i++)
			send_request(i, -i, 32'sh7FFFFFFF, corner_angle[i], corner_angle[(i + 3) % 10],
				corner_angle[(i + 7) % 10], one, -one, one);
		send_request(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0,
			32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
		send_request(-1, 1, 0, 32'sh002D0000, 32'sh002D0000, 32'sh002D0000,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_request(0, 0, 0, 32'sh00B40000, 32'sh010E0000, 32'sh005A0000, 0, 0, 0);
		in_valid <= 1'b0;

		// Random bursts with gaps
		for (int n = 0; n < RANDOM_REQUESTS; ) begin
			int burst;
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < RANDOM_REQUESTS; b++, n++)
				send_random();
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;

		wait (pending == 0);
		repeat (TOTAL_LAT + 10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* sim.f */
design/trs_pkg.sv
design/trs_angle_prep.sv
design/trs_cordic_cell.sv
design/trs_sincos.sv
design/trs_matrix.sv
design/trs_model_matrix_compose.sv
sim/trs_compose_checker.sv
sim/tb_trs_model_matrix_compose.sv
